@@ sv/fsbd_pkg.sv @@
// ----------------------------------------------------------------------------
// fsbd_pkg
// Shared types and constants for the stop-bit field decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package fsbd_pkg;

  // request kinds
  localparam logic [1:0] REQ_MAP   = 2'd0;
  localparam logic [1:0] REQ_BEGIN = 2'd1;
  localparam logic [1:0] REQ_DATA  = 2'd2;

  // field operators
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_COPY = 2'd1;
  localparam logic [1:0] OP_INCR = 2'd2;

  // result status codes
  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_INVALID    = 2'd1;
  localparam logic [1:0] STAT_INCOMPLETE = 2'd2;
  localparam logic [1:0] STAT_HEADER     = 2'd3;

  localparam int        PRESENCE_W = 35;
  localparam int        TEXT_CAP   = 16;
  localparam int        TEXT_IDX_W = 4;
  localparam int        STOP_POS   = 7;
  localparam logic [6:0] GROUP_MASK = 7'h7f;
  localparam logic [4:0] CHAR_SAT   = 5'd31;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       start_of_message;
    logic [4:0] field_slot;
    logic       field_is_text;
    logic [1:0] field_operator;
    logic       last_byte;
  } item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic commit;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic has_result;
    logic replay;
    logic out_free;
    logic last_char;
  } ctrl_sts_t;

endpackage

`default_nettype wire

@@ sv/fsbd_if.sv @@
// ----------------------------------------------------------------------------
// fsbd_if
// Valid/ready channels for request items and decoded results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsbd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       start_of_message;
  logic [4:0] field_slot;
  logic       field_is_text;
  logic [1:0] field_operator;
  logic       last_byte;

  modport source (
    output valid, req_type, data_byte, start_of_message, field_slot,
           field_is_text, field_operator, last_byte,
    input  ready
  );
  modport sink (
    input  valid, req_type, data_byte, start_of_message, field_slot,
           field_is_text, field_operator, last_byte,
    output ready
  );
endinterface

interface fsbd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_out;
  logic [4:0]  slot_out;
  logic        text_out;
  logic        from_store;
  logic        last_of_run;
  logic [1:0]  status;

  modport source (
    output valid, value_out, slot_out, text_out, from_store, last_of_run, status,
    input  ready
  );
  modport sink (
    input  valid, value_out, slot_out, text_out, from_store, last_of_run, status,
    output ready
  );
endinterface

`default_nettype wire

@@ sv/fsbd_ram.sv @@
// ----------------------------------------------------------------------------
// fsbd_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fsbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ sv/fsbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// fsbd_ctrl
// Sequencer: accept an item, execute it, then replay stored text if needed.
// ----------------------------------------------------------------------------
`default_nettype none

module fsbd_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fsbd_pkg::ctrl_sts_t sts,
  output fsbd_pkg::ctrl_cmd_t      cmd
);
  import fsbd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_REPLAY = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the output register can take the result
        if (!sts.has_result || sts.out_free) begin
          cmd.commit = 1'b1;
          state_next = sts.replay ? S_REPLAY : S_IDLE;
        end
      end
      S_REPLAY: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.last_char) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

@@ sv/fsbd_dp.sv @@
// ----------------------------------------------------------------------------
// fsbd_dp
// Datapath: presence map, field decode, slot store and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsbd_dp #(
  parameter int FIELD_SLOTS    = 32,
  parameter int MAX_PMAP_BYTES = 5,
  parameter int MAX_TEXT_LEN   = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire fsbd_pkg::item_t     item,
  input  wire fsbd_pkg::ctrl_cmd_t cmd,
  output fsbd_pkg::ctrl_sts_t      sts,
  fsbd_out_if.source               dout
);
  import fsbd_pkg::*;

  localparam int SW    = (FIELD_SLOTS > 1) ? $clog2(FIELD_SLOTS) : 1;
  localparam int NSLOT = 1 << SW;
  localparam int PCW   = $clog2(MAX_PMAP_BYTES + 1);
  localparam int TAW   = SW + 1 + TEXT_IDX_W;
  localparam logic [PCW-1:0] PMAP_LIMIT = PCW'(MAX_PMAP_BYTES);

  // latched item
  logic [1:0] r_req;
  logic [7:0] r_byte;
  logic       r_som;
  logic [4:0] r_slot;
  logic       r_txt;
  logic [1:0] r_op;
  logic       r_last;

  // decoder state
  logic [PRESENCE_W-1:0] pbits, pbits_next;
  logic [PCW-1:0]        pcount, pcount_next;
  logic                  pdone, pdone_next;
  logic [4:0]            cur_slot, cur_slot_next;
  logic                  cur_txt, cur_txt_next;
  logic [1:0]            cur_op, cur_op_next;
  logic                  active, active_next;
  logic [31:0]           acc, acc_next;
  logic [4:0]            cc, cc_next;
  logic [FIELD_SLOTS-1:0] slot_valid, slot_valid_next;
  logic [FIELD_SLOTS-1:0] val_written, val_written_next;
  logic [FIELD_SLOTS-1:0] bank, bank_next;

  // replay
  logic [TEXT_IDX_W-1:0] k, k_next;
  logic [4:0]            rp_len;

  // store ports
  logic          val_we;
  logic [SW-1:0] val_waddr;
  logic [31:0]   val_wdata;
  logic [31:0]   val_rdata;
  logic          len_we;
  logic [4:0]    len_wdata;
  logic [4:0]    len_rdata;
  logic          txt_we;
  logic [TAW-1:0] txt_waddr;
  logic [TAW-1:0] txt_raddr;
  logic [7:0]    txt_rdata;
  logic [SW-1:0] rd_idx;

  // result of the executed item
  logic        has_res;
  logic        replay;
  logic [31:0] res_value;
  logic [4:0]  res_slot;
  logic        res_text;
  logic        res_store;
  logic        res_last;
  logic [1:0]  res_status;

  logic          out_valid;
  logic          out_free;
  logic          load_out;

  logic [SW-1:0] r_idx;
  logic [SW-1:0] cur_idx;
  logic          in_range;
  logic          r_valid;
  logic [31:0]   vword;
  logic [6:0]    grp;
  logic [6:0]    ch;
  logic          stop;
  logic [PRESENCE_W-1:0] map_base;
  logic [PCW-1:0]        map_base_cnt;
  logic [PCW-1:0]        map_cnt;
  logic [5:0]            map_sh;
  logic [PRESENCE_W-1:0] map_bits;
  logic [31:0]           acc_sh;
  logic [4:0]            cc_inc;

  assign r_idx    = SW'(r_slot);
  assign cur_idx  = SW'(cur_slot);
  assign in_range = 6'(r_slot) < 6'(FIELD_SLOTS);
  assign r_valid  = in_range & slot_valid[r_idx];
  assign vword    = (in_range & val_written[r_idx]) ? val_rdata : 32'd0;
  assign stop     = r_byte[STOP_POS];
  assign ch       = r_byte[6:0] & GROUP_MASK;
  assign acc_sh   = {acc[24:0], ch};
  assign cc_inc   = (cc < CHAR_SAT) ? cc + 5'd1 : cc;

  // map byte bit 6 is the lowest-numbered presence bit of its group
  always_comb begin
    for (int j = 0; j < 7; j++) begin
      grp[j] = r_byte[6-j];
    end
  end

  assign map_base     = r_som ? '0 : pbits;
  assign map_base_cnt = r_som ? '0 : pcount;
  assign map_sh       = 6'(7 * map_base_cnt);
  assign map_bits     = map_base | (PRESENCE_W'(grp) << map_sh);
  assign map_cnt      = map_base_cnt + PCW'(1);

  always_comb begin
    pbits_next       = pbits;
    pcount_next      = pcount;
    pdone_next       = pdone;
    cur_slot_next    = cur_slot;
    cur_txt_next     = cur_txt;
    cur_op_next      = cur_op;
    active_next      = active;
    acc_next         = acc;
    cc_next          = cc;
    slot_valid_next  = slot_valid;
    val_written_next = val_written;
    bank_next        = bank;
    val_we     = 1'b0;
    val_waddr  = cur_idx;
    val_wdata  = acc_sh;
    len_we     = 1'b0;
    len_wdata  = 5'd0;
    txt_we     = 1'b0;
    txt_waddr  = {cur_idx, ~bank[cur_idx], cc[TEXT_IDX_W-1:0]};
    has_res    = 1'b0;
    replay     = 1'b0;
    res_value  = 32'd0;
    res_slot   = r_slot;
    res_text   = 1'b0;
    res_store  = 1'b0;
    res_last   = 1'b1;
    res_status = STAT_OK;

    unique case (r_req)
      REQ_MAP: begin
        if (r_som || !(pdone || pcount >= PMAP_LIMIT)) begin
          pbits_next  = map_bits;
          pcount_next = map_cnt;
          pdone_next  = 1'b0;
          if (r_som) begin
            active_next = 1'b0;
          end
          res_slot = 5'd0;
          if (stop) begin
            if (map_bits[0]) begin
              pdone_next = 1'b1;
            end else begin
              // slot zero must be present
              pcount_next = PMAP_LIMIT;
              has_res     = 1'b1;
              res_status  = STAT_HEADER;
            end
          end else if (map_cnt >= PMAP_LIMIT) begin
            has_res    = 1'b1;
            res_status = STAT_HEADER;
          end else if (r_last) begin
            pcount_next = PMAP_LIMIT;
            has_res     = 1'b1;
            res_status  = STAT_INCOMPLETE;
          end
        end
      end
      REQ_BEGIN: begin
        active_next = 1'b0;
        if (!pdone) begin
          has_res    = 1'b1;
          res_status = STAT_HEADER;
        end else if (!in_range) begin
          has_res    = 1'b1;
          res_status = STAT_INVALID;
        end else if (pbits[r_slot]) begin
          active_next   = 1'b1;
          cur_slot_next = r_slot;
          cur_txt_next  = r_txt;
          cur_op_next   = r_op;
          acc_next      = 32'd0;
          cc_next       = 5'd0;
        end else if (!r_txt) begin
          has_res = 1'b1;
          if (r_valid && (r_op == OP_COPY || r_op == OP_INCR)) begin
            res_value = (r_op == OP_INCR) ? vword + 32'd1 : vword;
            res_store = 1'b1;
            if (r_op == OP_INCR) begin
              val_we    = 1'b1;
              val_waddr = r_idx;
              val_wdata = vword + 32'd1;
              val_written_next[r_idx] = 1'b1;
            end
          end else begin
            res_status = STAT_INVALID;
          end
        end else if (r_valid && r_op == OP_COPY && len_rdata != 5'd0) begin
          replay = 1'b1;
        end else begin
          has_res    = 1'b1;
          res_status = STAT_INVALID;
        end
      end
      REQ_DATA: begin
        if (active) begin
          res_slot = cur_slot;
          if (!stop && r_last) begin
            active_next = 1'b0;
            has_res     = 1'b1;
            res_status  = STAT_INCOMPLETE;
          end else if (!cur_txt) begin
            acc_next = acc_sh;
            if (stop) begin
              active_next = 1'b0;
              has_res     = 1'b1;
              res_value   = acc_sh;
              if (cur_op == OP_COPY || cur_op == OP_INCR) begin
                slot_valid_next[cur_idx]  = 1'b1;
                val_written_next[cur_idx] = 1'b1;
                val_we = 1'b1;
                len_we = 1'b1;
              end
            end
          end else begin
            // text goes to the spare bank, swapped in on a good commit
            txt_we    = cc < 5'(TEXT_CAP);
            cc_next   = cc_inc;
            has_res   = 1'b1;
            res_value = 32'(ch);
            res_text  = 1'b1;
            res_last  = stop;
            if (stop) begin
              active_next = 1'b0;
              if (cur_op == OP_COPY) begin
                if (7'(cc_inc) <= 7'(MAX_TEXT_LEN) && cc_inc <= 5'(TEXT_CAP)) begin
                  slot_valid_next[cur_idx] = 1'b1;
                  bank_next[cur_idx]       = ~bank[cur_idx];
                  len_we    = 1'b1;
                  len_wdata = cc_inc;
                end else begin
                  slot_valid_next[cur_idx] = 1'b0;
                end
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // the next replay index drives the text read address of the registered read
  always_comb begin
    if (cmd.commit) begin
      k_next = '0;
    end else if (cmd.emit) begin
      k_next = k + TEXT_IDX_W'(1);
    end else begin
      k_next = k;
    end
  end

  assign txt_raddr = {r_idx, bank[r_idx], k_next};

  // keep reading the latched slot while the item waits to execute
  assign rd_idx = cmd.load ? SW'(item.field_slot) : r_idx;

  assign out_free = !out_valid || dout.ready;
  assign load_out = (cmd.commit && has_res) || cmd.emit;

  assign sts.has_result = has_res;
  assign sts.replay     = replay;
  assign sts.out_free   = out_free;
  assign sts.last_char  = (5'(k) + 5'd1) == rp_len;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r_req  <= item.req_type;
      r_byte <= item.data_byte;
      r_som  <= item.start_of_message;
      r_slot <= item.field_slot;
      r_txt  <= item.field_is_text;
      r_op   <= item.field_operator;
      r_last <= item.last_byte;
    end
    if (cmd.commit) begin
      rp_len <= len_rdata;
    end
    if (load_out) begin
      if (cmd.emit) begin
        dout.value_out   <= 32'(txt_rdata);
        dout.slot_out    <= r_slot;
        dout.text_out    <= 1'b1;
        dout.from_store  <= 1'b1;
        dout.last_of_run <= sts.last_char;
        dout.status      <= STAT_OK;
      end else begin
        dout.value_out   <= res_value;
        dout.slot_out    <= res_slot;
        dout.text_out    <= res_text;
        dout.from_store  <= res_store;
        dout.last_of_run <= res_last;
        dout.status      <= res_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pbits       <= '0;
      pcount      <= '0;
      pdone       <= 1'b0;
      cur_slot    <= 5'd0;
      cur_txt     <= 1'b0;
      cur_op      <= OP_NONE;
      active      <= 1'b0;
      acc         <= 32'd0;
      cc          <= 5'd0;
      slot_valid  <= '0;
      val_written <= '0;
      bank        <= '0;
      k           <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        pbits       <= pbits_next;
        pcount      <= pcount_next;
        pdone       <= pdone_next;
        cur_slot    <= cur_slot_next;
        cur_txt     <= cur_txt_next;
        cur_op      <= cur_op_next;
        active      <= active_next;
        acc         <= acc_next;
        cc          <= cc_next;
        slot_valid  <= slot_valid_next;
        val_written <= val_written_next;
        bank        <= bank_next;
      end
      k <= k_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign dout.valid = out_valid;

  fsbd_ram #(.WIDTH(32), .DEPTH(NSLOT)) u_value_ram (
    .clk   (clk),
    .we    (cmd.commit && val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (rd_idx),
    .rdata (val_rdata)
  );

  fsbd_ram #(.WIDTH(5), .DEPTH(NSLOT)) u_len_ram (
    .clk   (clk),
    .we    (cmd.commit && len_we),
    .waddr (cur_idx),
    .wdata (len_wdata),
    .raddr (rd_idx),
    .rdata (len_rdata)
  );

  fsbd_ram #(.WIDTH(8), .DEPTH(NSLOT * 2 * TEXT_CAP)) u_text_ram (
    .clk   (clk),
    .we    (cmd.commit && txt_we),
    .waddr (txt_waddr),
    .wdata ({1'b0, ch}),
    .raddr (txt_raddr),
    .rdata (txt_rdata)
  );

`ifndef SYNTHESIS
  a_done_has_slot0: assert property (@(posedge clk) disable iff (rst)
    pdone |-> pbits[0])
    else $error("presence map complete without slot zero");

  a_active_needs_map: assert property (@(posedge clk) disable iff (rst)
    active |-> pdone)
    else $error("field open without a complete presence map");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result loaded over a waiting beat");

  a_replay_len: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (rp_len != 5'd0 && rp_len <= 5'(TEXT_CAP)))
    else $error("replay with bad stored length");
`endif

endmodule

`default_nettype wire

@@ sv/fast_stop_bit_field_decoder.sv @@
// ----------------------------------------------------------------------------
// fast_stop_bit_field_decoder
// Decodes presence maps and stop-bit coded integer and text fields.
// ----------------------------------------------------------------------------
// usage:
//   din carries one request per beat: a presence-map byte, a field begin, or
//   a field data byte. dout carries decoded results (integers, text
//   characters, store replays and error codes), up to 16 per request.
//   an accepted request is captured while the slot store is read, then
//   executed; its result is registered onto dout at the execute edge. a
//   begin that replays stored text then gives one character per cycle while
//   dout is free, up to 16, from the text memory read port. a new request
//   is taken only after the last one has executed and its replay is done.
//   results sit in an output register; din is taken again while a result
//   waits there, and execution pauses only when a new result needs it.
//   if dout stalls, the block holds and nothing is lost.
//   reset clears the presence map, the open field and the per-slot valid
//   bits; the store memories need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module fast_stop_bit_field_decoder #(
  parameter int FIELD_SLOTS    = 32,
  parameter int MAX_PMAP_BYTES = 5,
  parameter int MAX_TEXT_LEN   = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  fsbd_in_if.sink    din,
  fsbd_out_if.source dout
);
  import fsbd_pkg::*;

  item_t      item;
  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;
  logic       in_ready;

  assign item.req_type         = din.req_type;
  assign item.data_byte        = din.data_byte;
  assign item.start_of_message = din.start_of_message;
  assign item.field_slot       = din.field_slot;
  assign item.field_is_text    = din.field_is_text;
  assign item.field_operator   = din.field_operator;
  assign item.last_byte        = din.last_byte;
  assign din.ready             = in_ready;

  fsbd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (din.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fsbd_dp #(
    .FIELD_SLOTS    (FIELD_SLOTS),
    .MAX_PMAP_BYTES (MAX_PMAP_BYTES),
    .MAX_TEXT_LEN   (MAX_TEXT_LEN)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cmd  (cmd),
    .sts  (sts),
    .dout (dout)
  );

endmodule

`default_nettype wire

@@ test/fsbd_decode_monitor.sv @@
// ----------------------------------------------------------------------------
// fsbd_decode_monitor
// Watches both channels of the stop-bit field decoder, keeps its own copy of
// the presence map, the open field and the slot store, and checks every
// result beat against the oldest predicted result.
// ----------------------------------------------------------------------------
`default_nettype none

module fsbd_decode_monitor
  import fsbd_pkg::*;
#(
  parameter int FIELD_SLOTS    = 32,
  parameter int MAX_PMAP_BYTES = 5,
  parameter int MAX_TEXT_LEN   = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  fsbd_in_if        din,
  fsbd_out_if       dout,
  output int        errors,
  output int        pending,
  output int        requests,
  output int        results,
  output int        replays
);

  localparam int SLOT_COUNT = 32;
  localparam int REPORT_CAP = 50;

  typedef struct packed {
    logic [31:0] value;
    logic [4:0]  slot;
    logic        text;
    logic        from_store;
    logic        last;
    logic [1:0]  status;
  } decoded_t;

  decoded_t decoded_q[$];

  // presence map and open field
  logic [PRESENCE_W-1:0] pmap;
  int                    pmap_bytes;
  bit                    pmap_ready;
  bit                    field_open;
  logic [4:0]            open_slot;
  bit                    open_text;
  logic [1:0]            open_op;
  logic [31:0]           acc;
  int                    chars;
  logic [7:0]            staging [TEXT_CAP];

  // per-slot store
  bit                    store_valid [SLOT_COUNT];
  logic [31:0]           store_value [SLOT_COUNT];
  int                    store_len   [SLOT_COUNT];
  logic [7:0]            store_text  [SLOT_COUNT][TEXT_CAP];

  initial begin
    errors   = 0;
    requests = 0;
    results  = 0;
    replays  = 0;
  end

  task automatic report(input string msg);
    errors++;
    if (errors <= REPORT_CAP) $display("%0t: %s", $time, msg);
  endtask

  task automatic clear_model();
    pmap       = '0;
    pmap_bytes = 0;
    pmap_ready = 0;
    field_open = 0;
    open_slot  = '0;
    open_text  = 0;
    open_op    = OP_NONE;
    acc        = '0;
    chars      = 0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      store_valid[s] = 0;
      store_value[s] = '0;
      store_len[s]   = 0;
      for (int k = 0; k < TEXT_CAP; k++) store_text[s][k] = '0;
    end
    for (int k = 0; k < TEXT_CAP; k++) staging[k] = '0;
  endtask

  task automatic queue_decoded(input logic [31:0] value, input logic [4:0] slot,
                               input logic text, input logic from_store,
                               input logic last, input logic [1:0] status);
    decoded_t d;
    d.value      = value;
    d.slot       = slot;
    d.text       = text;
    d.from_store = from_store;
    d.last       = last;
    d.status     = status;
    decoded_q.push_back(d);
  endtask

  task automatic decode_map_byte(input logic [7:0] b, input logic som, input logic last);
    int pos;
    if (som) begin
      pmap       = '0;
      pmap_bytes = 0;
      pmap_ready = 0;
      field_open = 0;
    end else if (pmap_ready || pmap_bytes >= MAX_PMAP_BYTES) begin
      return;
    end
    for (int j = 0; j < 7; j++) begin
      pos = 7 * pmap_bytes + j;
      if (pos < PRESENCE_W && b[6-j]) pmap[pos] = 1'b1;
    end
    pmap_bytes++;
    if (b[STOP_POS]) begin
      if (pmap[0]) begin
        pmap_ready = 1;
      end else begin
        // slot zero missing: map is dead until the next start of message
        pmap_bytes = MAX_PMAP_BYTES;
        queue_decoded('0, '0, 1'b0, 1'b0, 1'b1, STAT_HEADER);
      end
    end else if (pmap_bytes >= MAX_PMAP_BYTES) begin
      queue_decoded('0, '0, 1'b0, 1'b0, 1'b1, STAT_HEADER);
    end else if (last) begin
      pmap_bytes = MAX_PMAP_BYTES;
      queue_decoded('0, '0, 1'b0, 1'b0, 1'b1, STAT_INCOMPLETE);
    end
  endtask

  task automatic decode_begin(input logic [4:0] slot, input logic txt, input logic [1:0] op);
    int n;
    field_open = 0;
    if (!pmap_ready) begin
      queue_decoded('0, slot, 1'b0, 1'b0, 1'b1, STAT_HEADER);
      return;
    end
    if (int'(slot) >= FIELD_SLOTS) begin
      queue_decoded('0, slot, 1'b0, 1'b0, 1'b1, STAT_INVALID);
      return;
    end
    if (pmap[slot]) begin
      field_open = 1;
      open_slot  = slot;
      open_text  = txt;
      open_op    = op;
      acc        = '0;
      chars      = 0;
      return;
    end
    // absent field: value comes from the store
    if (!txt) begin
      if (store_valid[slot] && (op == OP_COPY || op == OP_INCR)) begin
        if (op == OP_INCR) store_value[slot] = store_value[slot] + 32'd1;
        queue_decoded(store_value[slot], slot, 1'b0, 1'b1, 1'b1, STAT_OK);
      end else begin
        queue_decoded('0, slot, 1'b0, 1'b0, 1'b1, STAT_INVALID);
      end
      return;
    end
    n = store_len[slot];
    if (store_valid[slot] && op == OP_COPY && n > 0 && n <= TEXT_CAP) begin
      for (int k = 0; k < n; k++)
        queue_decoded({24'd0, store_text[slot][k]}, slot, 1'b1, 1'b1, k == n - 1, STAT_OK);
    end else begin
      queue_decoded('0, slot, 1'b0, 1'b0, 1'b1, STAT_INVALID);
    end
  endtask

  task automatic decode_data_byte(input logic [7:0] b, input logic last);
    logic       stop;
    logic [6:0] ch;
    logic [4:0] s;
    stop = b[STOP_POS];
    ch   = b[6:0] & GROUP_MASK;
    s    = open_slot;
    if (!field_open) return;
    if (!stop && last) begin
      field_open = 0;
      queue_decoded('0, s, 1'b0, 1'b0, 1'b1, STAT_INCOMPLETE);
      return;
    end
    if (!open_text) begin
      acc = {acc[24:0], ch};
      if (!stop) return;
      field_open = 0;
      if (open_op == OP_COPY || open_op == OP_INCR) begin
        store_valid[s] = 1;
        store_value[s] = acc;
        store_len[s]   = 0;
      end
      queue_decoded(acc, s, 1'b0, 1'b0, 1'b1, STAT_OK);
      return;
    end
    if (chars < TEXT_CAP) staging[chars] = {1'b0, ch};
    if (chars < int'(CHAR_SAT)) chars++;
    queue_decoded({25'd0, ch}, s, 1'b1, 1'b0, stop, STAT_OK);
    if (stop) begin
      field_open = 0;
      if (open_op == OP_COPY) begin
        if (chars <= MAX_TEXT_LEN && chars <= TEXT_CAP) begin
          store_valid[s] = 1;
          for (int k = 0; k < chars; k++) store_text[s][k] = staging[k];
          store_len[s] = chars;
        end else begin
          store_valid[s] = 0;
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want, input logic [4:0] slot);
    if (got !== want)
      report($sformatf("%s mismatch on slot %0d: got %0h, expected %0h", name, slot, got, want));
  endtask

  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      clear_model();
      decoded_q.delete();
      pending <= 0;
    end else begin
      if (din.valid && din.ready) begin
        if (din.req_type != 2'd3) requests++;
        case (din.req_type)
          REQ_MAP:   decode_map_byte(din.data_byte, din.start_of_message, din.last_byte);
          REQ_BEGIN: decode_begin(din.field_slot, din.field_is_text, din.field_operator);
          REQ_DATA:  decode_data_byte(din.data_byte, din.last_byte);
          default:   ;
        endcase
      end
      if (dout.valid && dout.ready) begin
        results++;
        if (dout.from_store) replays++;
        if (decoded_q.size() == 0) begin
          report($sformatf("result beat with nothing expected: slot %0d value %0h status %0d",
                           dout.slot_out, dout.value_out, dout.status));
        end else begin
          want = decoded_q.pop_front();
          check_field("value_out", dout.value_out, want.value, want.slot);
          check_field("slot_out", 32'(dout.slot_out), 32'(want.slot), want.slot);
          check_field("text_out", 32'(dout.text_out), 32'(want.text), want.slot);
          check_field("from_store", 32'(dout.from_store), 32'(want.from_store), want.slot);
          check_field("last_of_run", 32'(dout.last_of_run), 32'(want.last), want.slot);
          check_field("status", 32'(dout.status), 32'(want.status), want.slot);
        end
      end
      pending <= decoded_q.size();
    end
  end

endmodule

`default_nettype wire

@@ test/tb_fast_stop_bit_field_decoder.sv @@
// ----------------------------------------------------------------------------
// tb_fast_stop_bit_field_decoder
// Drives the stop-bit field decoder with a directed set of messages and then
// random messages, noise and broken sequences, with random gaps on both
// channels and one long output stall. A monitor checks every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fast_stop_bit_field_decoder;
  import fsbd_pkg::*;

  localparam int FIELD_SLOTS    = 32;
  localparam int MAX_PMAP_BYTES = 5;
  localparam int MAX_TEXT_LEN   = 16;

  localparam int RANDOM_ITEMS = 70;
  localparam int CALM_AFTER   = 55;
  localparam int HOLD_AFTER   = 30;
  localparam int HOLD_CYCLES  = 400;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 40;

  logic clk;
  logic rst;

  fsbd_in_if  din_ch ();
  fsbd_out_if dout_ch ();

  int mon_errors;
  int mon_pending;
  int mon_requests;
  int mon_results;
  int mon_replays;

  bit in_random;
  bit calm;
  bit hold_off;
  int random_count;
  int rx_gap;
  int drain_wait;

  fast_stop_bit_field_decoder #(
    .FIELD_SLOTS    (FIELD_SLOTS),
    .MAX_PMAP_BYTES (MAX_PMAP_BYTES),
    .MAX_TEXT_LEN   (MAX_TEXT_LEN)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_ch),
    .dout (dout_ch)
  );

  fsbd_decode_monitor #(
    .FIELD_SLOTS    (FIELD_SLOTS),
    .MAX_PMAP_BYTES (MAX_PMAP_BYTES),
    .MAX_TEXT_LEN   (MAX_TEXT_LEN)
  ) mon (
    .clk      (clk),
    .rst      (rst),
    .din      (din_ch),
    .dout     (dout_ch),
    .errors   (mon_errors),
    .pending  (mon_pending),
    .requests (mon_requests),
    .results  (mon_results),
    .replays  (mon_replays)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic item_t mk(input logic [1:0] req, input logic [7:0] b, input logic som,
                               input logic [4:0] slot, input logic txt,
                               input logic [1:0] op, input logic last);
    item_t it;
    it.req_type         = req;
    it.data_byte        = b;
    it.start_of_message = som;
    it.field_slot       = slot;
    it.field_is_text    = txt;
    it.field_operator   = op;
    it.last_byte        = last;
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(input item_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      din_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    din_ch.valid            <= 1'b1;
    din_ch.req_type         <= it.req_type;
    din_ch.data_byte        <= it.data_byte;
    din_ch.start_of_message <= it.start_of_message;
    din_ch.field_slot       <= it.field_slot;
    din_ch.field_is_text    <= it.field_is_text;
    din_ch.field_operator   <= it.field_operator;
    din_ch.last_byte        <= it.last_byte;
    do @(posedge clk); while (din_ch.ready !== 1'b1);
    if (in_random && it.req_type != 2'd3) random_count++;
    if (random_count >= CALM_AFTER) calm = 1'b1;
    @(negedge clk);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 3);
    repeat (n)
      send_item(mk(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 5'($urandom),
                   1'($urandom), 2'($urandom), 1'($urandom)));
  endtask

  // one message: map bytes, then field begins with data for present fields
  task automatic gen_message(input bit force_long);
    logic [34:0] pbits;
    logic [6:0]  grp;
    logic [7:0]  b;
    logic [4:0]  slot;
    logic [1:0]  op;
    bit          broken, ok_map, present, stop, txt, cut_here, drop;
    int          nmap, nf, n, lim, cut, k, j, f, i;
    nmap  = ($urandom_range(0, 2) == 0) ? $urandom_range(2, MAX_PMAP_BYTES) : 1;
    pbits = 35'({$urandom(), $urandom()});
    if (force_long || $urandom_range(0, 11) != 0) pbits[0] = 1'b1;
    broken = !force_long && $urandom_range(0, 9) == 0;
    if (broken) nmap = MAX_PMAP_BYTES;
    cut = (broken && $urandom_range(0, 1) == 1) ? $urandom_range(0, MAX_PMAP_BYTES - 2) : -1;
    for (k = 0; k < nmap; k++) begin
      for (j = 0; j < 7; j++) grp[6-j] = pbits[7*k+j];
      b = {(k == nmap - 1) && !broken, grp};
      send_item(mk(REQ_MAP, b, k == 0, 5'($urandom), 1'($urandom), 2'($urandom), k == cut));
    end
    ok_map = !broken && pbits[0];
    lim    = (7 * nmap > 32) ? 31 : 7 * nmap - 1;
    nf     = broken ? 1 : $urandom_range(1, 5);
    for (f = 0; f < nf; f++) begin
      slot = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, lim));
      txt  = $urandom_range(0, 2) == 0;
      op   = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      if (force_long && f == 0) begin
        slot = '0;
        txt  = 1'b1;
        op   = OP_COPY;
      end
      send_item(mk(REQ_BEGIN, 8'($urandom), 1'($urandom), slot, txt, op, 1'($urandom)));
      present = ok_map && int'(slot) < 7 * nmap && pbits[slot];
      if (present) begin
        if (force_long && f == 0)
          n = MAX_TEXT_LEN + 1;
        else if (txt)
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(TEXT_CAP - 2, TEXT_CAP + 2)
                                          : $urandom_range(1, 6);
        else
          n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
          stop     = (i == n - 1);
          cut_here = !stop && !force_long && $urandom_range(0, 24) == 0;
          drop     = !stop && !force_long && $urandom_range(0, 29) == 0;
          b        = {stop, 7'($urandom)};
          send_item(mk(REQ_DATA, b, 1'($urandom), 5'($urandom), 1'($urandom), 2'($urandom),
                       cut_here || (stop && $urandom_range(0, 7) == 0)));
          if (cut_here || drop) break;
        end
      end
    end
  endtask

  // result side: random stalls, the long hold-off, none near the end
  initial begin
    dout_ch.ready = 1'b0;
    rx_gap        = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        dout_ch.ready <= 1'b0;
      end else if (calm) begin
        dout_ch.ready <= 1'b1;
      end else if (rx_gap > 0) begin
        dout_ch.ready <= 1'b0;
        rx_gap--;
      end else if ($urandom_range(0, 6) == 0) begin
        dout_ch.ready <= 1'b0;
        rx_gap = $urandom_range(0, 10);
      end else begin
        dout_ch.ready <= 1'b1;
      end
    end
  end

  // long output stall while requests keep coming, so the input backs up
  initial begin
    hold_off = 1'b0;
    wait (random_count >= HOLD_AFTER);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, mon_pending);
    $display("tb_fast_stop_bit_field_decoder: errors");
    $finish;
  end

  initial begin
    rst                     = 1'b1;
    in_random               = 1'b0;
    calm                    = 1'b0;
    random_count            = 0;
    drain_wait              = 0;
    din_ch.valid            = 1'b0;
    din_ch.req_type         = REQ_MAP;
    din_ch.data_byte        = '0;
    din_ch.start_of_message = 1'b0;
    din_ch.field_slot       = '0;
    din_ch.field_is_text    = 1'b0;
    din_ch.field_operator   = OP_NONE;
    din_ch.last_byte        = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // begin with no map, stray data, map without slot zero, extra map byte
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd3, 1'b0, OP_COPY, 1'b0));
    send_item(mk(REQ_DATA, 8'h85, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_MAP, 8'hbf, 1'b1, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_MAP, 8'hc0, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    // buffer ends inside the map, then a map that never stops
    send_item(mk(REQ_MAP, 8'h40, 1'b1, 5'd0, 1'b0, OP_NONE, 1'b1));
    send_item(mk(REQ_MAP, 8'h40, 1'b1, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_MAP, 8'h00, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_MAP, 8'h7f, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_MAP, 8'h2a, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_MAP, 8'h00, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    // good two-byte map with slots 0..13 present, then an extra map byte
    send_item(mk(REQ_MAP, 8'h7f, 1'b1, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_MAP, 8'hff, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_MAP, 8'h80, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd0, 1'b0, OP_COPY, 1'b0));
    send_item(mk(REQ_DATA, 8'h7f, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_DATA, 8'hff, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd1, 1'b1, OP_COPY, 1'b0));
    send_item(mk(REQ_DATA, 8'h41, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_DATA, 8'hc2, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd2, 1'b0, OP_INCR, 1'b0));
    send_item(mk(REQ_DATA, 8'h80, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    // message ends mid-field, and a field dropped by the next begin
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd3, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_DATA, 8'h05, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b1));
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd4, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_DATA, 8'h01, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd5, 1'b1, OP_NONE, 1'b0));
    send_item(mk(REQ_DATA, 8'hda, 1'b0, 5'd0, 1'b0, OP_NONE, 1'b1));
    // map with only slot zero: text replay, increment, text increment
    send_item(mk(REQ_MAP, 8'hc0, 1'b1, 5'd0, 1'b0, OP_NONE, 1'b0));
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd1, 1'b1, OP_COPY, 1'b0));
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd2, 1'b0, OP_INCR, 1'b0));
    send_item(mk(REQ_BEGIN, 8'h00, 1'b0, 5'd1, 1'b1, OP_INCR, 1'b0));

    in_random = 1'b1;
    gen_message(1'b1);
    while (random_count < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else gen_message(1'b0);
    end
    din_ch.valid <= 1'b0;

    while (mon_pending != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mon_pending != 0) $display("%0d expected results never arrived", mon_pending);
    $display("sent %0d requests, checked %0d results, %0d of them replayed from the store",
             mon_requests, mon_results, mon_replays);
    $display("included header and incomplete errors, dropped fields, long text, %0d-cycle stall",
             HOLD_CYCLES);
    if (mon_errors == 0 && mon_pending == 0) begin
      $display("tb_fast_stop_bit_field_decoder: clean");
    end else begin
      $display("tb_fast_stop_bit_field_decoder: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
sv/fsbd_pkg.sv
sv/fsbd_if.sv
sv/fsbd_ram.sv
sv/fsbd_ctrl.sv
sv/fsbd_dp.sv
sv/fast_stop_bit_field_decoder.sv
test/fsbd_decode_monitor.sv
test/tb_fast_stop_bit_field_decoder.sv
